@@ rtl/tdsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tdsm_pkg
// Shared types and constants for the table driven state machine engine.
// ----------------------------------------------------------------------------
package tdsm_pkg;

  // Default table sizes.
  localparam int TRANSITION_ENTRIES_DEF = 64;
  localparam int ACTION_ENTRIES_DEF     = 32;

  // Field widths.
  localparam int STATE_W   = 8;
  localparam int EVENT_W   = 8;
  localparam int INDEX_W   = 6;
  localparam int AIDX_W    = 5;
  localparam int TCOUNT_W  = 7;
  localparam int ACOUNT_W  = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;
  // Width used when comparing counts and indexes against table sizes.
  localparam int CMP_W     = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT     = 1'b1;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_WR_TRANS  = 2'd0,
    CMD_WR_ACTION = 2'd1,
    CMD_EVENT     = 2'd2,
    CMD_SET_STATE = 2'd3
  } cmd_t;

  // One input item.
  typedef struct packed {
    cmd_t               command;
    logic [INDEX_W-1:0] entry_index;
    logic [STATE_W-1:0] state_value;
    logic [EVENT_W-1:0] event_code;
    logic [STATE_W-1:0] next_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [STATE_W-1:0] current_state;
    logic               moved;
    logic               action_found;
    logic [AIDX_W-1:0]  action_index;
  } out_item_t;

  // One transition table entry as stored in memory.
  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [EVENT_W-1:0] evt;
    logic [STATE_W-1:0] next;
  } trans_entry_t;

  localparam int TRANS_ENTRY_W = $bits(trans_entry_t);

endpackage

@@ rtl/tdsm_in_if.sv @@
// ----------------------------------------------------------------------------
// tdsm_in_if
// Valid/ready channel that carries input items into the engine.
// ----------------------------------------------------------------------------
interface tdsm_in_if import tdsm_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tdsm_out_if.sv @@
// ----------------------------------------------------------------------------
// tdsm_out_if
// Valid/ready channel that carries result items out of the engine.
// ----------------------------------------------------------------------------
interface tdsm_out_if import tdsm_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tdsm_ram.sv @@
// ----------------------------------------------------------------------------
// tdsm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tdsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/table_driven_state_machine.sv @@
// ----------------------------------------------------------------------------
// table_driven_state_machine
// Programmable state machine engine with transition and action tables in RAM.
// ----------------------------------------------------------------------------
// Table writes and state loads go from acceptance straight to the done state,
// where the result is loaded for output. An event scans the transition table,
// then the action table, up to the clamped transition and action counts Nt and
// Na: each table has one read port and is scanned one entry per cycle, stopping
// at the first match. One item is in work at a time; the next item can be
// accepted in the cycle after its result is loaded. Reset clears the present
// state, both count registers and the control; the table RAMs are not cleared.
// ----------------------------------------------------------------------------
module table_driven_state_machine import tdsm_pkg::*; #(
  parameter int TRANSITION_ENTRIES = TRANSITION_ENTRIES_DEF,
  parameter int ACTION_ENTRIES     = ACTION_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tdsm_in_if.sink              in_chan,
  tdsm_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int TAW = (TRANSITION_ENTRIES > 1) ? $clog2(TRANSITION_ENTRIES) : 1;
  localparam int AAW = (ACTION_ENTRIES > 1) ? $clog2(ACTION_ENTRIES) : 1;
  localparam int TCW = $clog2(TRANSITION_ENTRIES + 1);
  localparam int ACW = $clog2(ACTION_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TSCAN = 4'b0010,
    ST_ASCAN = 4'b0100,
    ST_DONE  = 4'b1000
  } fsm_t;

  fsm_t                state_r, state_nxt;
  logic [TCOUNT_W-1:0] tcount_r;
  logic [ACOUNT_W-1:0] acount_r;
  logic [STATE_W-1:0]  present_r, present_nxt;
  logic [EVENT_W-1:0]  event_r;
  logic                moved_r, moved_nxt;
  logic                found_r, found_nxt;
  logic [AIDX_W-1:0]   aidx_r, aidx_nxt;
  logic [TCW-1:0]      tcnt_r, tcnt_nxt;
  logic [ACW-1:0]      acnt_r, acnt_nxt;
  logic                tpend_r, tpend_nxt;
  logic                apend_r, apend_nxt;
  logic [ACW-1:0]      apend_idx_r, apend_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  logic [TCW-1:0]      tn;
  logic [ACW-1:0]      an;
  logic                accept;
  logic                t_we, a_we;
  logic [TRANS_ENTRY_W-1:0] t_rdata;
  logic [STATE_W-1:0]  a_rdata;
  trans_entry_t        t_entry;
  logic                out_load;

  // Counts larger than a table are taken as the table size.
  always_comb begin
    tn = TCW'((CMP_W'(tcount_r) > CMP_W'(TRANSITION_ENTRIES))
              ? CMP_W'(TRANSITION_ENTRIES) : CMP_W'(tcount_r));
    an = ACW'((CMP_W'(acount_r) > CMP_W'(ACTION_ENTRIES))
              ? CMP_W'(ACTION_ENTRIES) : CMP_W'(acount_r));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcount_r <= '0;
      acount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRANSITION_COUNT: tcount_r <= cfg_data[TCOUNT_W-1:0];
        CFG_ACTION_COUNT:     acount_r <= cfg_data[ACOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // Table writes happen at acceptance; entries beyond a table are dropped.
  assign t_we = accept && (in_chan.data.command == CMD_WR_TRANS) &&
                (CMP_W'(in_chan.data.entry_index) < CMP_W'(TRANSITION_ENTRIES));
  assign a_we = accept && (in_chan.data.command == CMD_WR_ACTION) &&
                (CMP_W'(in_chan.data.entry_index) < CMP_W'(ACTION_ENTRIES));

  tdsm_ram #(
    .WIDTH (TRANS_ENTRY_W),
    .DEPTH (TRANSITION_ENTRIES),
    .AW    (TAW)
  ) u_trans_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (TAW'(in_chan.data.entry_index)),
    .wdata ({in_chan.data.state_value, in_chan.data.event_code,
             in_chan.data.next_value}),
    .raddr (TAW'(tcnt_r)),
    .rdata (t_rdata)
  );

  tdsm_ram #(
    .WIDTH (STATE_W),
    .DEPTH (ACTION_ENTRIES),
    .AW    (AAW)
  ) u_action_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (AAW'(in_chan.data.entry_index)),
    .wdata (in_chan.data.state_value),
    .raddr (AAW'(acnt_r)),
    .rdata (a_rdata)
  );

  assign t_entry  = trans_entry_t'(t_rdata);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // Sequencer: accept, scan transitions and actions for an event, hand off the result.
  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    moved_nxt     = moved_r;
    found_nxt     = found_r;
    aidx_nxt      = aidx_r;
    tcnt_nxt      = tcnt_r;
    acnt_nxt      = acnt_r;
    tpend_nxt     = 1'b0;
    apend_nxt     = 1'b0;
    apend_idx_nxt = apend_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          moved_nxt = 1'b0;
          found_nxt = 1'b0;
          aidx_nxt  = '0;
          tcnt_nxt  = '0;
          acnt_nxt  = '0;
          case (in_chan.data.command)
            CMD_EVENT:     state_nxt = ST_TSCAN;
            CMD_SET_STATE: begin
              present_nxt = in_chan.data.state_value;
              state_nxt   = ST_DONE;
            end
            default:       state_nxt = ST_DONE;
          endcase
        end
      end

      ST_TSCAN: begin
        // Issue one read a cycle; the entry read last cycle is checked now.
        if (tpend_r && (t_entry.state == present_r) && (t_entry.evt == event_r)) begin
          present_nxt = t_entry.next;
          moved_nxt   = 1'b1;
          state_nxt   = ST_ASCAN;
        end else if (!tpend_r && (tcnt_r >= tn)) begin
          state_nxt = ST_ASCAN;
        end else if (tcnt_r < tn) begin
          tcnt_nxt  = tcnt_r + 1'b1;
          tpend_nxt = 1'b1;
        end
      end

      ST_ASCAN: begin
        // Same scheme over the action table against the updated state.
        if (apend_r && (a_rdata == present_r)) begin
          found_nxt = 1'b1;
          aidx_nxt  = AIDX_W'(apend_idx_r);
          state_nxt = ST_DONE;
        end else if (!apend_r && (acnt_r >= an)) begin
          state_nxt = ST_DONE;
        end else if (acnt_r < an) begin
          acnt_nxt      = acnt_r + 1'b1;
          apend_nxt     = 1'b1;
          apend_idx_nxt = acnt_r;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid: set on load, cleared when the transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      tpend_r     <= 1'b0;
      apend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      tpend_r     <= tpend_nxt;
      apend_r     <= apend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    moved_r     <= moved_nxt;
    found_r     <= found_nxt;
    aidx_r      <= aidx_nxt;
    tcnt_r      <= tcnt_nxt;
    acnt_r      <= acnt_nxt;
    apend_idx_r <= apend_idx_nxt;
    if (accept) begin
      event_r <= in_chan.data.event_code;
    end
    if (out_load) begin
      out_data_r.current_state <= present_r;
      out_data_r.moved         <= moved_r;
      out_data_r.action_found  <= found_r;
      out_data_r.action_index  <= aidx_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule
